[src/pcbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared types and constants of the prefix code bit packer.
// ----------------------------------------------------------------------------
package pcbp_pkg;

    localparam int MAX_CODE_BITS = 32;
    localparam int SYMBOL_COUNT  = 256;

    localparam int WORD_BITS  = 32;
    localparam int LEN_W      = 6;
    localparam int REQ_W      = 2;
    localparam int SYM_W      = 8;
    localparam int BYTE_BITS  = 8;
    localparam int CNT_W      = 3;
    localparam int BUF_BITS   = WORD_BITS + BYTE_BITS;
    localparam int TOT_W      = 6;
    localparam int TBL_AW     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_CAP    = (MAX_CODE_BITS < WORD_BITS) ? MAX_CODE_BITS : WORD_BITS;
    localparam int ENTRY_W    = WORD_BITS + LEN_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FLUSH  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_EMIT
    } t_state;

endpackage

[src/prefix_code_bit_packer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_core
// Prefix code packer: per-symbol code table in block memory, byte output.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one request per transfer: a table load writes one
// symbol's code word and length, an encode appends that symbol's code bits
// (first bit at the byte MSB) and a flush emits the pending partial byte
// padded with zeros, only when bits are pending.
// The output channel carries one packed byte per transfer; o_last marks the
// final byte caused by one request.
// A load writes its table entry. An encode reads the table, merges the code
// into the bit buffer, then emits up to 4 bytes, one byte per cycle through
// the single output register while the output does not stall. A flush with
// pending bits skips the table read and the merge and emits its padded byte.
// Reset clears the table valid bits (every entry reads as absent), the
// pending bits and the output valid. A stall on the output holds the byte
// and pauses the emit loop; o_in_stall stays high until the request is done.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [pcbp_pkg::REQ_W-1:0]   i_req_type,
    input  logic [pcbp_pkg::SYM_W-1:0]   i_symbol,
    input  logic [pcbp_pkg::WORD_BITS-1:0] i_code_word,
    input  logic [pcbp_pkg::LEN_W-1:0]   i_code_length,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [pcbp_pkg::BYTE_BITS-1:0] o_out_byte,
    output logic                         o_last
);
    import pcbp_pkg::*;

    t_state                r_state;
    t_state                n_state;

    logic [ENTRY_W-1:0]    r_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_vld;
    logic [ENTRY_W-1:0]    r_rd_data;
    logic                  r_rd_vld;

    logic [BYTE_BITS-1:0]  r_pbits;
    logic [CNT_W-1:0]      r_pcount;
    logic [BUF_BITS-1:0]   r_buf;
    logic [TOT_W-1:0]      r_total;

    logic                  r_out_valid;
    logic [BYTE_BITS-1:0]  r_out_byte;
    logic                  r_last;

    logic                  w_accept;
    logic                  w_in_range;
    logic [TBL_AW-1:0]     w_idx;
    logic                  w_wr_en;
    logic [LEN_W-1:0]      w_len_cap;
    logic [WORD_BITS:0]    w_mask;
    logic [WORD_BITS-1:0]  w_rd_code;
    logic [LEN_W-1:0]      w_rd_len;
    logic [WORD_BITS-1:0]  w_code_l;
    logic [BUF_BITS-1:0]   w_merge_buf;
    logic [TOT_W-1:0]      w_merge_tot;
    logic                  w_slot_free;
    logic                  w_fire;
    logic                  w_done;
    logic                  w_flush_go;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_in_range = ({1'b0, i_symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
    assign w_idx      = i_symbol[TBL_AW-1:0];
    assign w_len_cap  = (i_code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : i_code_length;
    assign w_mask     = ((WORD_BITS + 1)'(1) << w_len_cap) - (WORD_BITS + 1)'(1);

    // table memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_idx] <= {i_code_word & w_mask[WORD_BITS-1:0], w_len_cap};
        end
        r_rd_data <= r_mem[w_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_vld[w_idx] <= 1'b1;
            end
            r_rd_vld <= r_vld[w_idx] && w_in_range;
        end
    end

    assign w_rd_code = r_rd_vld ? r_rd_data[ENTRY_W-1:LEN_W] : '0;
    assign w_rd_len  = r_rd_vld ? r_rd_data[LEN_W-1:0] : '0;

    // left-align the code, then place it after the pending bits
    assign w_code_l    = w_rd_code << (LEN_W'(WORD_BITS) - w_rd_len);
    assign w_merge_buf = {r_pbits, {WORD_BITS{1'b0}}}
                       | ({w_code_l, {BYTE_BITS{1'b0}}} >> r_pcount);
    assign w_merge_tot = TOT_W'(r_pcount) + TOT_W'(w_rd_len);

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_flush_go  = (r_pcount != '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_ENCODE && w_in_range) begin
                        n_state = ST_MERGE;
                    end else if (i_req_type == REQ_FLUSH && w_flush_go) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_MERGE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the controller
    always_comb begin
        o_in_stall = 1'b1;
        w_wr_en    = 1'b0;
        w_fire     = 1'b0;
        w_done     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                w_wr_en    = w_accept && (i_req_type == REQ_LOAD) && w_in_range;
            end
            ST_MERGE: begin
            end
            ST_EMIT: begin
                if (r_total >= TOT_W'(BYTE_BITS)) begin
                    w_fire = w_slot_free;
                    w_done = w_slot_free && (r_total < TOT_W'(2 * BYTE_BITS));
                end else begin
                    w_done = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pbits     <= '0;
            r_pcount    <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && w_accept && i_req_type == REQ_FLUSH && w_flush_go) begin
                r_buf   <= {r_pbits, {WORD_BITS{1'b0}}};
                r_total <= TOT_W'(BYTE_BITS);
            end
            if (r_state == ST_MERGE) begin
                r_buf   <= w_merge_buf;
                r_total <= w_merge_tot;
            end
            if (w_fire) begin
                r_buf   <= r_buf << BYTE_BITS;
                r_total <= r_total - TOT_W'(BYTE_BITS);
            end
            if (w_done) begin
                if (w_fire) begin
                    r_pbits  <= r_buf[BUF_BITS-BYTE_BITS-1:BUF_BITS-2*BYTE_BITS];
                    r_pcount <= CNT_W'(r_total - TOT_W'(BYTE_BITS));
                end else begin
                    r_pbits  <= r_buf[BUF_BITS-1:BUF_BITS-BYTE_BITS];
                    r_pcount <= r_total[CNT_W-1:0];
                end
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_byte <= r_buf[BUF_BITS-1:BUF_BITS-BYTE_BITS];
            r_last     <= (r_total < TOT_W'(2 * BYTE_BITS));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_last;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> r_total <= TOT_W'(BUF_BITS - 1))
        else $error("bit buffer count out of range");

    a_encode_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req_type == REQ_ENCODE && w_in_range) |=> r_state == ST_MERGE)
        else $error("encode transfer did not start a table read");

    a_flush_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req_type == REQ_FLUSH && r_pcount != '0)
        |=> (r_state == ST_EMIT && r_total == TOT_W'(BYTE_BITS)))
        else $error("flush did not load one padded byte");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_total < TOT_W'(2 * BYTE_BITS)) |=> (r_state == ST_IDLE && o_last))
        else $error("last byte did not end the request");

endmodule
